[design/scpa_pkg.sv]
// Shared types, constants and helpers for the size-class pool allocator.
// No dependencies; imported by scpa_class_sel and size_class_pool_allocator.
`default_nettype none

package scpa_pkg;

    localparam int NUM_CLASSES_DEF      = 4;
    localparam int BLOCKS_PER_CLASS_DEF = 256;
    localparam int NUM_CFG_REGS         = 4;
    localparam int SIZE_W               = 16;
    localparam int CLS_MAX_W            = 3;
    localparam int CFG_ADDR_W           = 4;
    localparam int CFG_DATA_W           = 32;
    localparam logic [SIZE_W-1:0] MIN_BLOCK_BYTES = 16'd8;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } t_status;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic                 found;
        logic [CLS_MAX_W-1:0] cls;
    } t_pick;

    // Block size of a class after reset: 16 bytes doubling per class.
    function automatic logic [SIZE_W-1:0] reset_size(input int c);
        logic [31:0] s;
        s = 32'd16 << c;
        return s[SIZE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/scpa_class_sel.sv]
// First-fit size class selection for allocate requests.
// Depends on scpa_pkg for the size width and the pick struct.
`default_nettype none

module scpa_class_sel #(
    parameter int NUM_CLASSES = scpa_pkg::NUM_CLASSES_DEF
) (
    input  wire logic [scpa_pkg::SIZE_W-1:0] i_sizes [NUM_CLASSES],
    input  wire logic [scpa_pkg::SIZE_W-1:0] i_request_size,
    output scpa_pkg::t_pick                  o_pick
);
    import scpa_pkg::*;

    logic [NUM_CLASSES-1:0] w_fits;

    // A block must hold a link, so sizes below the minimum count as the minimum.
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (i_sizes[c] < MIN_BLOCK_BYTES) begin
                w_fits[c] = (MIN_BLOCK_BYTES >= i_request_size);
            end else begin
                w_fits[c] = (i_sizes[c] >= i_request_size);
            end
        end
    end

    // Walk downwards so the lowest fitting class wins.
    always_comb begin
        o_pick = '0;
        if (i_request_size != '0) begin
            for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
                if (w_fits[c]) begin
                    o_pick.found = 1'b1;
                    o_pick.cls   = CLS_MAX_W'(c);
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/size_class_pool_allocator.sv]
// Top level of the size-class pool allocator: config registers, free-list heads,
// link memory and sequencing. Depends on scpa_pkg and scpa_class_sel.
//
//  Channel | Direction | Handshake              | Payload
//  in      | input     | i_in_valid / o_in_stall | operation, request_size, release_class,
//          |           |                         | release_block
//  out     | output    | o_out_valid / i_out_stall | status, granted_class, granted_block
//  cfg     | input     | APB psel/penable/pready | paddr, pwdata, prdata
//
// A release or a failed allocation is answered from the idle state; a successful
// allocation waits in the pop state for the registered link memory read of the next
// link before the head updates. After reset a clearing pass chains the link memory,
// one entry a cycle, over all 2**(clog2(NUM_CLASSES)+clog2(BLOCKS_PER_CLASS)) entries
// (1024 at the defaults); no beat is taken then.
// A stalled result in the output register holds off input; a new beat is taken
// at the earliest at the edge where the waiting result leaves.
`default_nettype none

module size_class_pool_allocator #(
    parameter int NUM_CLASSES      = scpa_pkg::NUM_CLASSES_DEF,
    parameter int BLOCKS_PER_CLASS = scpa_pkg::BLOCKS_PER_CLASS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_operation,
    input  wire logic [15:0]                       i_request_size,
    input  wire logic [1:0]                        i_release_class,
    input  wire logic [7:0]                        i_release_block,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [1:0]                             o_status,
    output logic [1:0]                             o_granted_class,
    output logic [7:0]                             o_granted_block,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [scpa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [scpa_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [scpa_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import scpa_pkg::*;

    localparam int BLK_W  = $clog2(BLOCKS_PER_CLASS);
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int LINK_W = BLK_W + 1;
    localparam int ADDR_W = CLS_W + BLK_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(BLOCKS_PER_CLASS);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_POP   = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [LINK_W-1:0]   r_head [NUM_CLASSES];
    logic [LINK_W-1:0]   n_head [NUM_CLASSES];
    logic [SIZE_W-1:0]   r_class_size [NUM_CLASSES];
    logic [CLS_W-1:0]    r_pop_cls, n_pop_cls;
    logic [BLK_W-1:0]    r_pop_blk, n_pop_blk;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_status, n_out_status;
    logic [1:0]          r_out_cls, n_out_cls;
    logic [7:0]          r_out_blk, n_out_blk;

    // link memory
    logic [LINK_W-1:0]   r_link_mem [DEPTH];
    logic [LINK_W-1:0]   r_rdata;
    logic [ADDR_W-1:0]   w_raddr, w_waddr;
    logic [LINK_W-1:0]   w_wdata;
    logic                w_we;

    t_pick               w_pick;
    logic [CLS_W-1:0]    w_pick_idx, w_rel_cls;
    logic [BLK_W-1:0]    w_rel_blk, w_clr_blk;
    logic [LINK_W-1:0]   w_pick_head, w_clr_link;
    logic                w_pick_empty, w_rel_ok, w_accept, w_out_free;
    logic                w_cfg_wr;
    logic [1:0]          w_cfg_idx;

    scpa_class_sel #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_class_sel (
        .i_sizes        (r_class_size),
        .i_request_size (i_request_size),
        .o_pick         (w_pick)
    );

    // handshakes
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (32'(w_cfg_idx) < NUM_CLASSES) begin
            prdata = CFG_DATA_W'(r_class_size[CLS_W'(w_cfg_idx)]);
        end
    end

    // decode
    assign w_pick_idx   = CLS_W'(w_pick.cls);
    assign w_pick_head  = r_head[w_pick_idx];
    assign w_pick_empty = (w_pick_head >= LINK_NONE);
    assign w_rel_cls    = CLS_W'(i_release_class);
    assign w_rel_blk    = BLK_W'(i_release_block);
    assign w_rel_ok     = (32'(i_release_class) < NUM_CLASSES)
                       && (32'(i_release_block) < BLOCKS_PER_CLASS);

    assign w_clr_blk  = r_clr_addr[BLK_W-1:0];
    assign w_clr_link = (32'(w_clr_blk) + 32'd1 < BLOCKS_PER_CLASS)
                      ? LINK_W'(w_clr_blk) + LINK_W'(1) : LINK_NONE;

    // memory ports
    assign w_raddr = {w_pick_idx, w_pick_head[BLK_W-1:0]};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = w_clr_link;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end else if (w_accept && (i_operation == OP_RELEASE) && w_rel_ok) begin
            w_we    = 1'b1;
            w_waddr = {w_rel_cls, w_rel_blk};
            w_wdata = r_head[w_rel_cls];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_link_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_link_mem[w_raddr];
    end

    // sequencing
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_head       = r_head;
        n_pop_cls    = r_pop_cls;
        n_pop_blk    = r_pop_blk;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_cls    = r_out_cls;
        n_out_blk    = r_out_blk;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_out_cls = '0;
                    n_out_blk = '0;
                    if (i_operation == OP_RELEASE) begin
                        n_out_valid = 1'b1;
                        if (w_rel_ok) begin
                            n_out_status      = ST_OK;
                            n_head[w_rel_cls] = LINK_W'(w_rel_blk);
                        end else begin
                            n_out_status = ST_UNSUPPORTED;
                        end
                    end else if (!w_pick.found) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_UNSUPPORTED;
                    end else if (w_pick_empty) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_EMPTY;
                    end else begin
                        // wait in the pop state for the registered read of the next link
                        n_pop_cls = w_pick_idx;
                        n_pop_blk = w_pick_head[BLK_W-1:0];
                        n_state   = S_POP;
                    end
                end
            end
            S_POP: begin
                n_head[r_pop_cls] = r_rdata;
                n_out_valid       = 1'b1;
                n_out_status      = ST_OK;
                n_out_cls         = 2'(r_pop_cls);
                n_out_blk         = 8'(r_pop_blk);
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]       <= '0;
                r_class_size[c] <= reset_size(c);
            end
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            if (w_cfg_wr && (32'(w_cfg_idx) < NUM_CLASSES)
                    && (32'(w_cfg_idx) < NUM_CFG_REGS)) begin
                r_class_size[CLS_W'(w_cfg_idx)] <= pwdata[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_cls    <= n_pop_cls;
        r_pop_blk    <= n_pop_blk;
        r_out_status <= n_out_status;
        r_out_cls    <= n_out_cls;
        r_out_blk    <= n_out_blk;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_class = r_out_cls;
    assign o_granted_block = r_out_blk;

    // checks
    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("input beat taken during link clearing");

    a_pop_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> $past(w_accept && (i_operation == OP_ALLOC)))
        else $error("pop cycle without an accepted allocation");

    a_pop_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (o_out_valid && (o_status == ST_OK)))
        else $error("pop did not load a successful result");

    a_pop_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_head[r_pop_cls] == LINK_W'(r_pop_blk)))
        else $error("head moved before the pop completed");

endmodule

`default_nettype wire
